@@ rtl/core/cfd_pkg.sv @@
// Shared types and constants for the command frame decoder.
package cfd_pkg;

  // Frame sizing
  localparam int FREQ_DIGITS = 9;
  localparam int COUNT_W     = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int FREQ_W      = 30;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Characters with a framing meaning
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 1'd1;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RESET = 30'd30000;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = 30'd470000000;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BAD_FRAME   = 4'd1,
    ST_UNKNOWN_CMD = 4'd2,
    ST_FREQ_LEN    = 4'd3,
    ST_NON_DIGIT   = 4'd4,
    ST_OUT_OF_RANGE = 4'd5,
    ST_BAD_MODE    = 4'd6,
    ST_BAD_MD      = 4'd7,
    ST_BAD_TX      = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    REQ_GET_FREQ = 3'd0,
    REQ_SET_FREQ = 3'd1,
    REQ_GET_MODE = 3'd2,
    REQ_SET_MODE = 3'd3,
    REQ_GET_TX   = 3'd4,
    REQ_SET_TX   = 3'd5
  } req_kind_t;

  // Frame state seen by the decoder
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         mnemonic0;
    logic [7:0]         mnemonic1;
    logic [7:0]         payload0;
    logic [7:0]         payload1;
    logic [FREQ_W-1:0]  freq_accum;
    logic               all_digits;
  } frame_t;

  // One decoded request
  typedef struct packed {
    status_t           status;
    req_kind_t         request_kind;
    logic              vfo_sel;
    logic [FREQ_W-1:0] freq_hz;
    logic [3:0]        mode_code;
    logic              tx_on;
    logic              wants_response;
  } result_t;

endpackage

@@ rtl/core/cfd_frame_state.sv @@
// Per-frame state: byte count, mnemonic, first payload bytes, digit accumulator.
module cfd_frame_state
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] in_byte,
  output frame_t     frame
);

  // empty frame: everything zero, digits-only flag set
  localparam frame_t FRAME_CLEAR = '{
    byte_count: '0,
    mnemonic0:  '0,
    mnemonic1:  '0,
    payload0:   '0,
    payload1:   '0,
    freq_accum: '0,
    all_digits: 1'b1
  };

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

  frame_t frame_next;
  logic [COUNT_W-1:0] pos;
  logic               is_digit;
  logic [FREQ_W+3:0]  acc_wide;

  assign pos      = frame.byte_count - COUNT_W'(2);
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  // times ten plus the digit, saturated at the field max
  assign acc_wide = {1'b0, frame.freq_accum, 3'b000} + {3'b000, frame.freq_accum, 1'b0}
                  + {(FREQ_W+4-8)'(0), in_byte - CHAR_ZERO};

  // next frame state for one word
  always_comb begin
    frame_next = frame;
    if (in_byte == CHAR_SEMI) begin
      frame_next = FRAME_CLEAR;
    end else begin
      if (frame.byte_count < COUNT_W'(2)) begin
        if (frame.byte_count[0]) frame_next.mnemonic1 = upcase(in_byte);
        else                     frame_next.mnemonic0 = upcase(in_byte);
      end else begin
        if (pos == COUNT_W'(0)) frame_next.payload0 = in_byte;
        if (pos == COUNT_W'(1)) frame_next.payload1 = in_byte;
        if (is_digit) begin
          if (frame.byte_count < COUNT_W'(FREQ_DIGITS + 2)) begin
            frame_next.freq_accum = (acc_wide > {4'b0000, FREQ_MAX}) ? FREQ_MAX
                                                                     : acc_wide[FREQ_W-1:0];
          end
        end else begin
          frame_next.all_digits = 1'b0;
        end
      end
      if (frame.byte_count != COUNT_MAX) frame_next.byte_count = frame.byte_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= FRAME_CLEAR;
    end else if (advance) begin
      frame <= frame_next;
    end
  end

endmodule

@@ rtl/core/cfd_decode.sv @@
// Decodes a finished frame into one request or an error status.
module cfd_decode
  import cfd_pkg::*;
(
  input  frame_t            frame,
  input  logic [FREQ_W-1:0] min_freq_hz,
  input  logic [FREQ_W-1:0] max_freq_hz,
  output result_t           result
);

  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_B   = 8'h42;
  localparam logic [7:0] CHAR_D   = 8'h44;
  localparam logic [7:0] CHAR_E   = 8'h45;
  localparam logic [7:0] CHAR_F   = 8'h46;
  localparam logic [7:0] CHAR_M   = 8'h4D;
  localparam logic [7:0] CHAR_T   = 8'h54;
  localparam logic [7:0] CHAR_X   = 8'h58;
  localparam logic [3:0] MODE_BAD = 4'd15;

  // '1'..'9' map to 0..8, 'A'..'E' to 9..13
  function automatic logic [3:0] mode_index(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    mode_index = MODE_BAD;
    if (c >= CHAR_ONE && c <= CHAR_NINE) begin
      d          = c - CHAR_ONE;
      mode_index = d[3:0];
    end else if (c >= CHAR_A && c <= CHAR_E) begin
      d          = c - CHAR_A + 8'd9;
      mode_index = d[3:0];
    end
  endfunction

  logic [COUNT_W-1:0] cnt;
  logic [3:0]         mode;
  logic               p0_zero;

  assign cnt     = frame.byte_count;
  assign mode    = mode_index(frame.payload1);
  assign p0_zero = (frame.payload0 == CHAR_ZERO);

  // command dispatch
  always_comb begin
    result = '0;
    if (cnt < COUNT_W'(2)) begin
      result.status = ST_BAD_FRAME;
    end else if (frame.mnemonic0 == CHAR_F &&
                 (frame.mnemonic1 == CHAR_A || frame.mnemonic1 == CHAR_B)) begin
      if (cnt == COUNT_W'(2)) begin
        result.request_kind   = REQ_GET_FREQ;
        result.vfo_sel        = (frame.mnemonic1 == CHAR_B);
        result.wants_response = 1'b1;
      end else if (cnt != COUNT_W'(FREQ_DIGITS + 2)) begin
        result.status = ST_FREQ_LEN;
      end else if (!frame.all_digits) begin
        result.status = ST_NON_DIGIT;
      end else if (frame.freq_accum < min_freq_hz || frame.freq_accum > max_freq_hz) begin
        result.status = ST_OUT_OF_RANGE;
      end else begin
        result.request_kind = REQ_SET_FREQ;
        result.vfo_sel      = (frame.mnemonic1 == CHAR_B);
        result.freq_hz      = frame.freq_accum;
      end
    end else if (frame.mnemonic0 == CHAR_M && frame.mnemonic1 == CHAR_D) begin
      if (cnt == COUNT_W'(3) && p0_zero) begin
        result.request_kind   = REQ_GET_MODE;
        result.wants_response = 1'b1;
      end else if (cnt == COUNT_W'(4) && p0_zero) begin
        if (mode > 4'd13) begin
          result.status = ST_BAD_MODE;
        end else begin
          result.request_kind = REQ_SET_MODE;
          result.mode_code    = mode;
        end
      end else begin
        result.status = ST_BAD_MD;
      end
    end else if (frame.mnemonic0 == CHAR_T && frame.mnemonic1 == CHAR_X) begin
      if (cnt == COUNT_W'(2)) begin
        result.request_kind   = REQ_GET_TX;
        result.wants_response = 1'b1;
      end else if (cnt == COUNT_W'(3) && (p0_zero || frame.payload0 == CHAR_ONE)) begin
        result.request_kind = REQ_SET_TX;
        result.tx_on        = (frame.payload0 == CHAR_ONE);
      end else begin
        result.status = ST_BAD_TX;
      end
    end else begin
      result.status = ST_UNKNOWN_CMD;
    end
  end

endmodule

@@ rtl/core/cat_command_frame_decoder.sv @@
// Top level of the text command frame decoder.
// Takes one character word per cycle while in_stall is low and gives one decoded
// request word for every ';' (other characters give nothing). A word goes through an
// input register, then frame state update and decode, into the result register; one
// word per cycle is sustained while out_stall is low. in_stall rises only when a ';'
// sits in the input register while the result register holds a word that is stalled.
// The frequency bounds are written through cfg_wr_en/cfg_index/cfg_data.
module cat_command_frame_decoder
  import cfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           status,
  output logic [2:0]           request_kind,
  output logic                 vfo_sel,
  output logic [FREQ_W-1:0]    freq_hz,
  output logic [3:0]           mode_code,
  output logic                 tx_on,
  output logic                 wants_response,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data
);

  logic [FREQ_W-1:0] min_freq_hz;
  logic [FREQ_W-1:0] max_freq_hz;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_semi;
  logic              s1_go;
  logic              out_free;
  frame_t            frame;
  result_t           dec_result;
  result_t           out_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq_hz <= MIN_FREQ_RESET;
      max_freq_hz <= MAX_FREQ_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_FREQ: min_freq_hz <= cfg_data;
        CFG_MAX_FREQ: max_freq_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: only ';' needs room in the result register
  assign out_free = !out_valid || !out_stall;
  assign s1_semi  = (s1_byte == CHAR_SEMI);
  assign s1_go    = s1_valid && (!s1_semi || out_free);
  assign in_stall = s1_valid && !s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_byte <= in_byte;
  end

  cfd_frame_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_go),
    .in_byte (s1_byte),
    .frame   (frame)
  );

  cfd_decode u_decode (
    .frame       (frame),
    .min_freq_hz (min_freq_hz),
    .max_freq_hz (max_freq_hz),
    .result      (dec_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_semi) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_semi) out_word <= dec_result;
  end

  assign status         = out_word.status;
  assign request_kind   = out_word.request_kind;
  assign vfo_sel        = out_word.vfo_sel;
  assign freq_hz        = out_word.freq_hz;
  assign mode_code      = out_word.mode_code;
  assign tx_on          = out_word.tx_on;
  assign wants_response = out_word.wants_response;

endmodule

@@ rtl/core/cfd_checker.sv @@
// Port-level checks for the command frame decoder, bound to the top level.
module cfd_checker
  import cfd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [3:0]        status,
  input logic [2:0]        request_kind,
  input logic              vfo_sel,
  input logic [FREQ_W-1:0] freq_hz,
  input logic [3:0]        mode_code,
  input logic              tx_on,
  input logic              wants_response
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // an error word carries nothing but its status
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      request_kind == REQ_GET_FREQ && !vfo_sel && freq_hz == '0 &&
      mode_code == 4'd0 && !tx_on && !wants_response)
    else $error("error word has stray fields");

  // queries only come from the get kinds
  a_query_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && wants_response |->
      status == ST_OK && (request_kind == REQ_GET_FREQ ||
      request_kind == REQ_GET_MODE || request_kind == REQ_GET_TX))
    else $error("query flag on a set request");

  // frequency only on set-frequency requests
  a_freq_only_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_kind != REQ_SET_FREQ |-> freq_hz == '0)
    else $error("frequency on a non set-frequency word");

endmodule

bind cat_command_frame_decoder cfd_checker u_cfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .request_kind   (request_kind),
  .vfo_sel        (vfo_sel),
  .freq_hz        (freq_hz),
  .mode_code      (mode_code),
  .tx_on          (tx_on),
  .wants_response (wants_response)
);
